// File: sv/sship_pkg.sv
// Shared types and constants for the SSH identification line parser.
`timescale 1ns / 1ps
`default_nettype none

package sship_pkg;

  localparam int FW         = 11;    // width of the offset and length result fields
  localparam int FIELD_MAX  = 2047;  // offsets and lengths saturate here
  localparam int MIN_LEN    = 9;
  localparam int PREFIX_LEN = 4;
  localparam int MATCH_LEN  = 7;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Result item; the first member below sits in the highest bits, so is_ssh lands in bit 0.
  typedef struct packed {
    logic [3:0]    pad;
    logic          overflow;
    logic          server_flag;
    logic [FW-1:0] soft_length;
    logic [FW-1:0] soft_start;
    logic [FW-1:0] proto_length;
    logic          is_ssh;
  } sship_result_t;

  // Characters of the "SSH-" prefix.
  function automatic logic [7:0] prefix_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h53;
      2'd1:    c = 8'h53;
      2'd2:    c = 8'h48;
      default: c = 8'h2d;
    endcase
    return c;
  endfunction

  // Characters of the server banner text that sets server_flag.
  function automatic logic [7:0] match_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h4f;
      3'd1:    c = 8'h70;
      3'd2:    c = 8'h65;
      3'd3:    c = 8'h6e;
      3'd4:    c = 8'h53;
      3'd5:    c = 8'h53;
      3'd6:    c = 8'h48;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/ssh_ident_line_parser.sv
// SSH identification line parser: byte-stream scanner with one verdict per payload.
`timescale 1ns / 1ps
`default_nettype none

// Takes one payload byte per cycle, sustained while the result register can take
// each verdict, with tlast on the final byte, and emits one verdict item per
// payload. Each byte is held in an input register, then a single pass of
// comparators and position registers updates the running scan; on the final
// byte the verdict is formed in the same pass and is registered into the result
// register. A stalled result register holds back the next final byte, and the
// input behind it, never the bytes before it. Positions are counted in a counter
// sized from MAX_BYTES; bytes beyond MAX_BYTES are dropped and the verdict then
// reports overflow only.
module ssh_ident_line_parser
  import sship_pkg::*;
#(
  parameter int MAX_BYTES = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // final_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // [0] is_ssh, [11:1] proto_length,
                                       // [22:12] soft_start, [33:23] soft_length,
                                       // [34] server_flag, [35] overflow, [39:36] zero
);

  localparam int PW = $clog2(MAX_BYTES + 1);
  localparam int XW = (PW > FW) ? PW : FW;

  // Input register.
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;

  // Scan state.
  logic [PW-1:0] pos_r, pos_nxt;
  logic          prefix_ok_r, prefix_ok_nxt;
  logic          prev_cr_r, prev_cr_nxt;
  logic [PW-1:0] crlf_pos_r, crlf_pos_nxt;
  logic          crlf_seen_r, crlf_seen_nxt;
  logic [PW-1:0] lf_pos_r, lf_pos_nxt;
  logic          lf_seen_r, lf_seen_nxt;
  logic [PW-1:0] dash_pos_r, dash_pos_nxt;
  logic          dash_seen_r, dash_seen_nxt;
  logic [PW-1:0] space_pos_r, space_pos_nxt;
  logic          space_seen_r, space_seen_nxt;
  logic [2:0]    match_prog_r, match_prog_nxt;
  logic [PW-1:0] match_end_r, match_end_nxt;
  logic          match_seen_r, match_seen_nxt;
  logic          ovf_r, ovf_nxt;

  // Result register.
  logic          out_valid_r;
  sship_result_t out_r, res_nxt;

  logic out_free, s1_fire, take;
  logic [2:0] k_cur, k_new;

  logic [XW-1:0] x_len, x_line_end, x_dash, x_space, x_soft_end, x_match_end;
  logic [XW-1:0] x_proto, x_start, x_soft_len;
  logic          line_ok;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_fire;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  // Per-byte scan update.
  always_comb begin
    pos_nxt        = pos_r;
    prefix_ok_nxt  = prefix_ok_r;
    prev_cr_nxt    = prev_cr_r;
    crlf_pos_nxt   = crlf_pos_r;
    crlf_seen_nxt  = crlf_seen_r;
    lf_pos_nxt     = lf_pos_r;
    lf_seen_nxt    = lf_seen_r;
    dash_pos_nxt   = dash_pos_r;
    dash_seen_nxt  = dash_seen_r;
    space_pos_nxt  = space_pos_r;
    space_seen_nxt = space_seen_r;
    match_prog_nxt = match_prog_r;
    match_end_nxt  = match_end_r;
    match_seen_nxt = match_seen_r;

    take    = pos_r < PW'(MAX_BYTES);
    ovf_nxt = ovf_r || !take;

    k_cur = (match_prog_r < 3'(MATCH_LEN)) ? match_prog_r : 3'd0;
    if (s1_byte_r == match_char(k_cur)) begin
      k_new = k_cur + 3'd1;
    end else begin
      k_new = (s1_byte_r == match_char(3'd0)) ? 3'd1 : 3'd0;
    end

    if (take) begin
      if (pos_r < PW'(PREFIX_LEN) && s1_byte_r != prefix_char(pos_r[1:0])) begin
        prefix_ok_nxt = 1'b0;
      end
      if (prev_cr_r && s1_byte_r == CH_LF && !crlf_seen_r) begin
        crlf_seen_nxt = 1'b1;
        crlf_pos_nxt  = pos_r - PW'(1);
      end
      prev_cr_nxt = (s1_byte_r == CH_CR);
      if (s1_byte_r == CH_LF && !lf_seen_r) begin
        lf_seen_nxt = 1'b1;
        lf_pos_nxt  = pos_r;
      end
      if (dash_seen_r && !space_seen_r && s1_byte_r == CH_SPACE) begin
        space_seen_nxt = 1'b1;
        space_pos_nxt  = pos_r;
      end
      if (!dash_seen_r && pos_r >= PW'(PREFIX_LEN) && s1_byte_r == CH_DASH) begin
        dash_seen_nxt = 1'b1;
        dash_pos_nxt  = pos_r;
      end
      if (!match_seen_r) begin
        if (k_new == 3'(MATCH_LEN)) begin
          match_seen_nxt = 1'b1;
          match_end_nxt  = pos_r + PW'(1);
          match_prog_nxt = 3'd0;
        end else begin
          match_prog_nxt = k_new;
        end
      end
      pos_nxt = pos_r + PW'(1);
    end
  end

  // Verdict, formed from the scan state including the final byte.
  always_comb begin
    x_len       = XW'(pos_nxt);
    x_dash      = XW'(dash_pos_nxt);
    x_space     = XW'(space_pos_nxt);
    x_match_end = XW'(match_end_nxt);
    if (crlf_seen_nxt) begin
      x_line_end = XW'(crlf_pos_nxt);
    end else if (lf_seen_nxt) begin
      x_line_end = XW'(lf_pos_nxt);
    end else begin
      x_line_end = x_len;
    end
    x_soft_end = (space_seen_nxt && x_space < x_line_end) ? x_space : x_line_end;
    x_proto    = x_dash - XW'(PREFIX_LEN);
    x_start    = x_dash + XW'(1);
    x_soft_len = x_soft_end - x_start;

    line_ok = x_len >= XW'(MIN_LEN) && prefix_ok_nxt && dash_seen_nxt &&
              x_dash < x_line_end;

    res_nxt = '0;
    if (ovf_nxt) begin
      res_nxt.overflow = 1'b1;
    end else if (line_ok) begin
      res_nxt.is_ssh       = 1'b1;
      res_nxt.proto_length = (x_proto > XW'(FIELD_MAX)) ? FW'(FIELD_MAX) : x_proto[FW-1:0];
      res_nxt.soft_start   = (x_start > XW'(FIELD_MAX)) ? FW'(FIELD_MAX) : x_start[FW-1:0];
      res_nxt.soft_length  = (x_soft_len > XW'(FIELD_MAX)) ? FW'(FIELD_MAX)
                                                           : x_soft_len[FW-1:0];
      res_nxt.server_flag  = match_seen_nxt && x_match_end <= x_line_end;
    end
  end

  // Control and scan state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      pos_r        <= '0;
      prefix_ok_r  <= 1'b1;
      prev_cr_r    <= 1'b0;
      crlf_pos_r   <= '0;
      crlf_seen_r  <= 1'b0;
      lf_pos_r     <= '0;
      lf_seen_r    <= 1'b0;
      dash_pos_r   <= '0;
      dash_seen_r  <= 1'b0;
      space_pos_r  <= '0;
      space_seen_r <= 1'b0;
      match_prog_r <= '0;
      match_end_r  <= '0;
      match_seen_r <= 1'b0;
      ovf_r        <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_fire && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (s1_fire) begin
        if (s1_last_r) begin
          // The verdict is out; start clean for the next payload.
          pos_r        <= '0;
          prefix_ok_r  <= 1'b1;
          prev_cr_r    <= 1'b0;
          crlf_pos_r   <= '0;
          crlf_seen_r  <= 1'b0;
          lf_pos_r     <= '0;
          lf_seen_r    <= 1'b0;
          dash_pos_r   <= '0;
          dash_seen_r  <= 1'b0;
          space_pos_r  <= '0;
          space_seen_r <= 1'b0;
          match_prog_r <= '0;
          match_end_r  <= '0;
          match_seen_r <= 1'b0;
          ovf_r        <= 1'b0;
        end else begin
          pos_r        <= pos_nxt;
          prefix_ok_r  <= prefix_ok_nxt;
          prev_cr_r    <= prev_cr_nxt;
          crlf_pos_r   <= crlf_pos_nxt;
          crlf_seen_r  <= crlf_seen_nxt;
          lf_pos_r     <= lf_pos_nxt;
          lf_seen_r    <= lf_seen_nxt;
          dash_pos_r   <= dash_pos_nxt;
          dash_seen_r  <= dash_seen_nxt;
          space_pos_r  <= space_pos_nxt;
          space_seen_r <= space_seen_nxt;
          match_prog_r <= match_prog_nxt;
          match_end_r  <= match_end_nxt;
          match_seen_r <= match_seen_nxt;
          ovf_r        <= ovf_nxt;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_fire && s1_last_r) begin
      out_r <= res_nxt;
    end
  end

  a_clean_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (pos_r == '0 && !ovf_r && !dash_seen_r && prefix_ok_r))
    else $error("scan state not cleared after a verdict");

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(MAX_BYTES))
    else $error("byte position beyond MAX_BYTES");

  a_ovf_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.overflow) |-> (!out_r.is_ssh && !out_r.server_flag &&
                                         out_r.proto_length == '0))
    else $error("overflow verdict carries line fields");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.is_ssh) |-> (out_r.soft_start == '0 && out_r.soft_length == '0 &&
                                        !out_r.server_flag))
    else $error("invalid verdict carries nonzero fields");

  a_space_after_dash: assert property (@(posedge clk) disable iff (!rst_n)
    space_seen_r |-> (dash_seen_r && space_pos_r > dash_pos_r))
    else $error("space recorded before the first dash");

endmodule

`default_nettype wire

// File: tb/ssh_ident_line_parser_tb.sv
// Self-checking testbench for the SSH identification line parser.
`timescale 1ns / 1ps

module ssh_ident_line_parser_tb;
  import sship_pkg::*;

  localparam int MAX_BYTES = 2048;
  localparam int RANDOM_BYTES = 1450;

  localparam bit [0:3][7:0] SSH_TAG = "SSH-";
  // Server banner text that raises server_flag.
  localparam bit [0:6][7:0] BANNER = {8'h4f, 8'h70, 8'h65, 8'h6e, 8'h53, 8'h53, 8'h48};

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  // Tracks the running scan of the current payload and holds the verdicts still owed.
  class verdict_scoreboard;
    bit [11:0] pos;
    bit        prefix_good;
    bit        last_cr;
    bit [10:0] crlf_at;
    bit        crlf_hit;
    bit [10:0] lf_at;
    bit        lf_hit;
    bit [10:0] dash_at;
    bit        dash_hit;
    bit [10:0] space_at;
    bit        space_hit;
    bit [2:0]  banner_run;
    bit [11:0] banner_end;
    bit        banner_hit;
    bit        overran;
    sship_result_t expected_verdicts[$];
    int fail_count;

    function new();
      fail_count = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      pos = '0;
      prefix_good = 1'b1;
      last_cr = 1'b0;
      crlf_at = '0;
      crlf_hit = 1'b0;
      lf_at = '0;
      lf_hit = 1'b0;
      dash_at = '0;
      dash_hit = 1'b0;
      space_at = '0;
      space_hit = 1'b0;
      banner_run = '0;
      banner_end = '0;
      banner_hit = 1'b0;
      overran = 1'b0;
    endfunction

    function bit [FW-1:0] clip(int v);
      return (v > FIELD_MAX) ? FW'(FIELD_MAX) : FW'(v);
    endfunction

    function void complain(string msg);
      fail_count++;
      if (fail_count <= 10) $display("[%0t] %s", $realtime, msg);
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    // Advances the scan by one accepted item; a final item yields the verdict.
    function void scan_byte(bit [7:0] b, bit fin);
      int p;
      int k;
      int line_end;
      int soft_end;
      sship_result_t v;
      if (pos >= MAX_BYTES) begin
        overran = 1'b1;
      end else begin
        p = pos;
        if (p < PREFIX_LEN && b != SSH_TAG[p]) prefix_good = 1'b0;
        if (last_cr && b == CH_LF && !crlf_hit) begin
          crlf_hit = 1'b1;
          crlf_at = 11'(p - 1);
        end
        last_cr = (b == CH_CR);
        if (b == CH_LF && !lf_hit) begin
          lf_hit = 1'b1;
          lf_at = 11'(p);
        end
        // The space test looks at the dash state before this item updates it.
        if (dash_hit && !space_hit && b == CH_SPACE) begin
          space_hit = 1'b1;
          space_at = 11'(p);
        end
        if (!dash_hit && p >= PREFIX_LEN && b == CH_DASH) begin
          dash_hit = 1'b1;
          dash_at = 11'(p);
        end
        if (!banner_hit) begin
          k = (banner_run < MATCH_LEN) ? int'(banner_run) : 0;
          if (b == BANNER[k]) k++;
          else k = (b == BANNER[0]) ? 1 : 0;
          if (k >= MATCH_LEN) begin
            banner_hit = 1'b1;
            banner_end = 12'(p + 1);
            k = 0;
          end
          banner_run = 3'(k);
        end
        pos = 12'(p + 1);
      end
      if (!fin) return;

      v = '0;
      if (overran) begin
        v.overflow = 1'b1;
      end else begin
        line_end = crlf_hit ? int'(crlf_at) : (lf_hit ? int'(lf_at) : int'(pos));
        if (int'(pos) >= MIN_LEN && prefix_good && dash_hit && int'(dash_at) < line_end) begin
          soft_end = (space_hit && int'(space_at) < line_end) ? int'(space_at) : line_end;
          v.is_ssh = 1'b1;
          v.proto_length = clip(int'(dash_at) - PREFIX_LEN);
          v.soft_start = clip(int'(dash_at) + 1);
          v.soft_length = clip(soft_end - int'(dash_at) - 1);
          v.server_flag = banner_hit && int'(banner_end) <= line_end;
        end
      end
      expected_verdicts.push_back(v);
      clear_scan();
    endfunction

    function void check_verdict(logic [39:0] raw);
      sship_result_t got;
      sship_result_t want;
      got = raw;
      if (expected_verdicts.size() == 0) begin
        complain($sformatf("verdict with none expected: %h", raw));
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.is_ssh !== want.is_ssh || got.proto_length !== want.proto_length ||
          got.soft_start !== want.soft_start || got.soft_length !== want.soft_length ||
          got.server_flag !== want.server_flag || got.overflow !== want.overflow)
        complain($sformatf({"verdict mismatch: expected ssh=%0d proto=%0d start=%0d ",
                            "len=%0d server=%0d ovf=%0d, got ssh=%0d proto=%0d start=%0d ",
                            "len=%0d server=%0d ovf=%0d"},
                           want.is_ssh, want.proto_length, want.soft_start,
                           want.soft_length, want.server_flag, want.overflow,
                           got.is_ssh, got.proto_length, got.soft_start,
                           got.soft_length, got.server_flag, got.overflow));
    endfunction

    function void flag_leftovers();
      if (expected_verdicts.size() != 0)
        complain($sformatf("%0d verdicts never arrived", expected_verdicts.size()));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [39:0] out_tdata;

  verdict_scoreboard sb = new();
  bit [7:0] payload[$];
  int burst_left = 0;
  int rx_cycle = 0;
  rx_mode_t rx_mode = RX_OPEN;

  ssh_ident_line_parser #(.MAX_BYTES(MAX_BYTES)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.scan_byte(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) sb.check_verdict(out_tdata);
  end

  // The receiver switches between open, random and periodic stall patterns.
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 250 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:     out_tready <= 1'b1;
      RX_LIGHT:    out_tready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY:    out_tready <= ($urandom_range(0, 2) == 0);
      RX_PERIODIC: out_tready <= ((rx_cycle % 11) > 6);
      default:     out_tready <= 1'b1;
    endcase
  end

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) payload.push_back(s[i]);
  endfunction

  function automatic void add_fill(bit [7:0] c, int n);
    repeat (n) payload.push_back(c);
  endfunction

  function automatic void add_banner();
    for (int i = 0; i < MATCH_LEN; i++) payload.push_back(BANNER[i]);
  endfunction

  function automatic void add_crlf();
    payload.push_back(CH_CR);
    payload.push_back(CH_LF);
  endfunction

  function automatic void add_pick(string set, int n);
    repeat (n) payload.push_back(set[$urandom_range(0, set.len() - 1)]);
  endfunction

  function automatic void add_noise(int n);
    repeat (n) payload.push_back(8'($urandom_range(0, 255)));
  endfunction

  // A well-formed identification line with random content and a random ending.
  function automatic void build_line();
    int n;
    add_text("SSH-");
    if ($urandom_range(0, 2) == 0) add_text("2.0");
    else add_pick("0123456789.", $urandom_range(0, 4));
    payload.push_back(CH_DASH);
    n = $urandom_range(0, 10);
    if ($urandom_range(0, 4) < 2) begin
      add_pick("abcXYZ019_.", $urandom_range(0, 3));
      add_banner();
    end
    add_pick("abcdefghijklmnopqrstuvwxyz0123456789_.-", n);
    if ($urandom_range(0, 1) == 1) begin
      payload.push_back(CH_SPACE);
      add_pick("abc xyz-019.", $urandom_range(0, 8));
    end
    case ($urandom_range(0, 3))
      0: add_crlf();
      1: payload.push_back(CH_LF);
      2: payload.push_back(CH_CR);
      default: ;
    endcase
    if ($urandom_range(0, 1) == 1) add_noise($urandom_range(1, 4));
  endfunction

  task automatic send_payload();
    int gap;
    for (int i = 0; i < payload.size(); i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      in_tvalid <= 1'b1;
      in_tdata <= payload[i];
      in_tlast <= (i == payload.size() - 1);
      @(posedge clk);
      while (in_tready !== 1'b1) @(posedge clk);
      burst_left--;
    end
    payload.delete();
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int waited;
    int cut;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Server line with banner, comment and CR LF ending.
    add_text("SSH-2.0-"); add_banner(); add_text("_9.6 build7"); add_crlf(); send_payload();
    add_text("SSH-1.99-srv"); payload.push_back(CH_LF); send_payload();
    // No line break: the line runs to the payload end.
    add_text("SSH-2.0-abc"); send_payload();
    // Dash only after the line end.
    add_text("SSH-2.0"); add_crlf(); add_text("-x"); send_payload();
    add_text("SSH-2-a"); send_payload();
    add_text("SSH-2.0-a"); send_payload();
    add_text("SSX-2.0-abc"); add_crlf(); send_payload();
    add_text("SSH-2.0abcdef"); send_payload();
    // Banner past the line end, then banner ending exactly at it.
    add_text("SSH-2.0-x"); add_crlf(); add_banner(); send_payload();
    add_text("SSH-2.0-"); add_banner(); add_crlf(); send_payload();
    // A broken start of the banner that restarts the match.
    add_text("SSH-2.0-Op"); add_banner(); payload.push_back(CH_LF); send_payload();
    // A later CR LF wins over an earlier bare LF.
    add_text("SSH-2.0-ab"); payload.push_back(CH_LF); add_text("cd"); add_crlf(); send_payload();
    add_text("SSH- 2.0-ab cd"); add_crlf(); send_payload();
    add_text("SSH--abcdefg"); send_payload();
    add_text("SSH-2.0- x"); payload.push_back(CH_LF); send_payload();
    add_text("SSH-2.0-ab"); payload.push_back(CH_CR); add_crlf(); send_payload();
    payload.push_back(CH_LF); send_payload();
    add_fill(8'hff, 9); send_payload();
    add_fill(8'h00, 9); send_payload();
    // Dash in the last slot: the software start saturates.
    add_text("SSH-"); add_fill("a", MAX_BYTES - 5); payload.push_back(CH_DASH); send_payload();
    add_text("SSH-2.0-"); add_fill("b", MAX_BYTES - 8); send_payload();
    add_text("SSH-2.0-"); add_fill("b", MAX_BYTES - 7); send_payload();
    wait_drained();

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        7: add_noise($urandom_range(1, 16));
        8: begin
          build_line();
          if ($urandom_range(0, 1) == 1) begin
            payload[$urandom_range(0, payload.size() - 1)] = 8'($urandom_range(0, 255));
          end else begin
            cut = $urandom_range(1, payload.size());
            while (payload.size() > cut) void'(payload.pop_back());
          end
        end
        9: add_pick("SSH- Op\n\r", $urandom_range(1, 12));
        default: build_line();
      endcase
      sent += payload.size();
      send_payload();
      if ($urandom_range(0, 14) == 0) wait_drained();
    end

    in_tvalid <= 1'b0;
    waited = 0;
    while (sb.pending() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    sb.flag_leftovers();
    if (sb.fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
